// ===== src/rbrl_pkg.sv =====
`timescale 1ns / 1ps

package rbrl_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 12;

    // configuration port
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_FIRST    = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_STOP     = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COL_FIRST    = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COL_STOP     = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RUN_MIN      = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RUN_MAX      = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_COLOR = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRAY_MODE    = 4'd7;

    // colour
    localparam int COLOR_BITS = 24;
    localparam int CHAN_BITS  = 8;
    localparam logic [COLOR_BITS-1:0] TARGET_COLOR_RST = 24'hD9D9D9;

    // run counter
    localparam int RUN_CNT_BITS = 2;
    localparam logic [RUN_CNT_BITS-1:0] RUN_CNT_ONE    = 2'd1;
    localparam logic [RUN_CNT_BITS-1:0] RUN_CNT_BUTTON = 2'd2;

    typedef enum logic [1:0] {
        PH_ROW   = 2'd0,
        PH_COL   = 2'd1,
        PH_FOUND = 2'd2
    } t_phase;

    // per-pixel compare result
    typedef struct packed {
        logic hit;
        logic in_win;
    } t_match;

endpackage

// ===== src/raster_button_run_locator.sv =====
`timescale 1ns / 1ps
// a frame end item reaches o_valid through the input and result registers
// throughput: one pixel item per cycle, set by the single compare and count
// step between the input and result registers, unless a frame end item waits
// for the result register; only the frame end item yields a result, others none
// reset: synchronous active low, clears scan state and loads register defaults

module raster_button_run_locator #(
    parameter int COORD_BITS = rbrl_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // pixel channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [COORD_BITS-1:0]              i_pix_col,
    input  logic [COORD_BITS-1:0]              i_pix_row,
    input  logic [rbrl_pkg::CHAN_BITS-1:0]     i_red,
    input  logic [rbrl_pkg::CHAN_BITS-1:0]     i_green,
    input  logic [rbrl_pkg::CHAN_BITS-1:0]     i_blue,
    input  logic [rbrl_pkg::CHAN_BITS-1:0]     i_gray,
    input  logic                               i_frame_end,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_found,
    output logic [COORD_BITS-1:0]              o_center_col,
    output logic [COORD_BITS-1:0]              o_center_row,
    output logic [COORD_BITS-1:0]              o_btn_width,
    output logic [COORD_BITS-1:0]              o_btn_height,
    // configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rbrl_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [rbrl_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    logic [COORD_BITS-1:0]           w_row_first, w_row_stop, w_col_first, w_col_stop;
    logic [COORD_BITS-1:0]           w_run_min, w_run_max;
    logic [rbrl_pkg::COLOR_BITS-1:0] w_target_color;
    logic                            w_gray_mode;

    logic                            r_in_valid;
    logic [COORD_BITS-1:0]           r_col, r_row;
    logic [rbrl_pkg::CHAN_BITS-1:0]  r_red, r_green, r_blue, r_gray;
    logic                            r_fe;

    logic                            w_accept, w_drain, w_advance;
    rbrl_pkg::t_match                w_match;
    logic                            w_res_valid, w_found;
    logic [COORD_BITS-1:0]           w_ccol, w_crow, w_width, w_height;

    logic                            r_out_valid;
    logic                            r_found;
    logic [COORD_BITS-1:0]           r_ccol, r_crow, r_width, r_height;

    assign o_cfg_ready = 1'b1;

    rbrl_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_row_first    (w_row_first),
        .o_row_stop     (w_row_stop),
        .o_col_first    (w_col_first),
        .o_col_stop     (w_col_stop),
        .o_run_min      (w_run_min),
        .o_run_max      (w_run_max),
        .o_target_color (w_target_color),
        .o_gray_mode    (w_gray_mode)
    );

    // handshake: the input stage holds only while a frame end item
    // waits for the result register
    assign w_drain   = r_out_valid && !i_stall;
    assign w_advance = r_in_valid && !(r_fe && r_out_valid && !w_drain);
    assign o_stall   = r_in_valid && !w_advance;
    assign w_accept  = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_col   <= i_pix_col;
            r_row   <= i_pix_row;
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_gray  <= i_gray;
            r_fe    <= i_frame_end;
        end
    end

    rbrl_match #(.COORD_BITS(COORD_BITS)) u_match (
        .i_col          (r_col),
        .i_row          (r_row),
        .i_red          (r_red),
        .i_green        (r_green),
        .i_blue         (r_blue),
        .i_gray         (r_gray),
        .i_row_first    (w_row_first),
        .i_row_stop     (w_row_stop),
        .i_col_first    (w_col_first),
        .i_col_stop     (w_col_stop),
        .i_target_color (w_target_color),
        .i_gray_mode    (w_gray_mode),
        .o_match        (w_match)
    );

    rbrl_scan #(.COORD_BITS(COORD_BITS)) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_advance),
        .i_match      (w_match),
        .i_col        (r_col),
        .i_row        (r_row),
        .i_frame_end  (r_fe),
        .i_row_stop   (w_row_stop),
        .i_run_min    (w_run_min),
        .i_run_max    (w_run_max),
        .o_res_valid  (w_res_valid),
        .o_found      (w_found),
        .o_center_col (w_ccol),
        .o_center_row (w_crow),
        .o_btn_width  (w_width),
        .o_btn_height (w_height)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (w_drain) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_found  <= w_found;
            r_ccol   <= w_ccol;
            r_crow   <= w_crow;
            r_width  <= w_width;
            r_height <= w_height;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_found;
    assign o_center_col = r_ccol;
    assign o_center_row = r_crow;
    assign o_btn_width  = r_width;
    assign o_btn_height = r_height;

endmodule

// ===== src/rbrl_cfg.sv =====
`timescale 1ns / 1ps

module rbrl_cfg #(
    parameter int COORD_BITS = rbrl_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [rbrl_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [rbrl_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output logic [COORD_BITS-1:0]              o_row_first,
    output logic [COORD_BITS-1:0]              o_row_stop,
    output logic [COORD_BITS-1:0]              o_col_first,
    output logic [COORD_BITS-1:0]              o_col_stop,
    output logic [COORD_BITS-1:0]              o_run_min,
    output logic [COORD_BITS-1:0]              o_run_max,
    output logic [rbrl_pkg::COLOR_BITS-1:0]    o_target_color,
    output logic                               o_gray_mode
);

    localparam logic [COORD_BITS-1:0] ALL_ONES = '1;
    localparam logic [COORD_BITS-1:0] ONE      = COORD_BITS'(1);

    logic [COORD_BITS-1:0]           r_row_first, r_row_stop, r_col_first, r_col_stop;
    logic [COORD_BITS-1:0]           r_run_min, r_run_max;
    logic [rbrl_pkg::COLOR_BITS-1:0] r_target_color;
    logic                            r_gray_mode;
    logic [COORD_BITS-1:0]           w_v;

    assign w_v = i_cfg_data[COORD_BITS-1:0];

    // register file, written one register per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_first    <= '0;
            r_row_stop     <= ALL_ONES;
            r_col_first    <= '0;
            r_col_stop     <= ALL_ONES;
            r_run_min      <= ONE;
            r_run_max      <= ALL_ONES;
            r_target_color <= rbrl_pkg::TARGET_COLOR_RST;
            r_gray_mode    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rbrl_pkg::CFG_ROW_FIRST:    r_row_first    <= w_v;
                rbrl_pkg::CFG_ROW_STOP:     r_row_stop     <= w_v;
                rbrl_pkg::CFG_COL_FIRST:    r_col_first    <= w_v;
                rbrl_pkg::CFG_COL_STOP:     r_col_stop     <= w_v;
                rbrl_pkg::CFG_RUN_MIN:      r_run_min      <= w_v;
                rbrl_pkg::CFG_RUN_MAX:      r_run_max      <= w_v;
                rbrl_pkg::CFG_TARGET_COLOR:
                    r_target_color <= i_cfg_data[rbrl_pkg::COLOR_BITS-1:0];
                rbrl_pkg::CFG_GRAY_MODE:    r_gray_mode    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_row_first    = r_row_first;
    assign o_row_stop     = r_row_stop;
    assign o_col_first    = r_col_first;
    assign o_col_stop     = r_col_stop;
    assign o_run_min      = r_run_min;
    assign o_run_max      = r_run_max;
    assign o_target_color = r_target_color;
    assign o_gray_mode    = r_gray_mode;

endmodule

// ===== src/rbrl_match.sv =====
`timescale 1ns / 1ps

module rbrl_match #(
    parameter int COORD_BITS = rbrl_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]            i_col,
    input  logic [COORD_BITS-1:0]            i_row,
    input  logic [rbrl_pkg::CHAN_BITS-1:0]   i_red,
    input  logic [rbrl_pkg::CHAN_BITS-1:0]   i_green,
    input  logic [rbrl_pkg::CHAN_BITS-1:0]   i_blue,
    input  logic [rbrl_pkg::CHAN_BITS-1:0]   i_gray,
    input  logic [COORD_BITS-1:0]            i_row_first,
    input  logic [COORD_BITS-1:0]            i_row_stop,
    input  logic [COORD_BITS-1:0]            i_col_first,
    input  logic [COORD_BITS-1:0]            i_col_stop,
    input  logic [rbrl_pkg::COLOR_BITS-1:0]  i_target_color,
    input  logic                             i_gray_mode,
    output rbrl_pkg::t_match                 o_match
);

    logic w_rgb_hit, w_gray_hit;

    // colour compare
    assign w_rgb_hit  = (i_red   == i_target_color[23:16]) &&
                        (i_green == i_target_color[15:8]) &&
                        (i_blue  == i_target_color[7:0]);
    assign w_gray_hit = (i_gray == i_target_color[7:0]);

    assign o_match.hit    = i_gray_mode ? w_gray_hit : w_rgb_hit;
    // window test, bounds exclusive at the stop side
    assign o_match.in_win = (i_row >= i_row_first) && (i_row < i_row_stop) &&
                            (i_col >= i_col_first) && (i_col < i_col_stop);

endmodule

// ===== src/rbrl_scan.sv =====
`timescale 1ns / 1ps

module rbrl_scan #(
    parameter int COORD_BITS = rbrl_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  rbrl_pkg::t_match      i_match,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic [COORD_BITS-1:0] i_row,
    input  logic                  i_frame_end,
    input  logic [COORD_BITS-1:0] i_row_stop,
    input  logic [COORD_BITS-1:0] i_run_min,
    input  logic [COORD_BITS-1:0] i_run_max,
    output logic                  o_res_valid,
    output logic                  o_found,
    output logic [COORD_BITS-1:0] o_center_col,
    output logic [COORD_BITS-1:0] o_center_row,
    output logic [COORD_BITS-1:0] o_btn_width,
    output logic [COORD_BITS-1:0] o_btn_height
);

    localparam logic [COORD_BITS-1:0] ALL_ONES = '1;
    localparam logic [COORD_BITS-1:0] ONE      = COORD_BITS'(1);

    rbrl_pkg::t_phase                  r_phase, n_phase;
    logic [COORD_BITS-1:0]             r_len, n_len;
    logic [rbrl_pkg::RUN_CNT_BITS-1:0] r_cnt, n_cnt;
    logic [COORD_BITS-1:0]             r_cur_row, n_cur_row;
    logic [COORD_BITS-1:0]             r_end_col, n_end_col;
    logic [COORD_BITS-1:0]             r_height, n_height;
    logic [COORD_BITS-1:0]             r_crow, n_crow;
    logic [COORD_BITS-1:0]             r_ccol, n_ccol;

    logic [COORD_BITS-1:0]             w_base_len;
    logic [rbrl_pkg::RUN_CNT_BITS-1:0] w_base_cnt, w_cnt_inc;
    logic                              w_found;

    // state registers, cleared after each frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= rbrl_pkg::PH_ROW;
            r_len     <= '0;
            r_cnt     <= '0;
            r_cur_row <= '0;
            r_end_col <= '0;
            r_height  <= '0;
            r_crow    <= '0;
            r_ccol    <= '0;
        end else if (i_en) begin
            if (i_frame_end) begin
                r_phase   <= rbrl_pkg::PH_ROW;
                r_len     <= '0;
                r_cnt     <= '0;
                r_cur_row <= '0;
                r_end_col <= '0;
                r_height  <= '0;
                r_crow    <= '0;
                r_ccol    <= '0;
            end else begin
                r_phase   <= n_phase;
                r_len     <= n_len;
                r_cnt     <= n_cnt;
                r_cur_row <= n_cur_row;
                r_end_col <= n_end_col;
                r_height  <= n_height;
                r_crow    <= n_crow;
                r_ccol    <= n_ccol;
            end
        end
    end

    // a row change during row scan restarts the run bookkeeping
    assign w_base_len = (i_row != r_cur_row) ? '0 : r_len;
    assign w_base_cnt = (i_row != r_cur_row) ? '0 : r_cnt;
    assign w_cnt_inc  = w_base_cnt + rbrl_pkg::RUN_CNT_ONE;

    // next state for the current pixel
    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_cur_row = r_cur_row;
        n_end_col = r_end_col;
        n_height  = r_height;
        n_crow    = r_crow;
        n_ccol    = r_ccol;
        unique case (r_phase)
            rbrl_pkg::PH_ROW: begin
                n_cur_row = i_row;
                n_len     = w_base_len;
                n_cnt     = w_base_cnt;
                if (i_match.in_win) begin
                    if (i_match.hit) begin
                        if (w_base_len != ALL_ONES) begin
                            n_len = w_base_len + ONE;
                        end
                    end else begin
                        n_len = '0;
                        if ((w_base_len >= i_run_min) && (w_base_len <= i_run_max)) begin
                            n_cnt = w_cnt_inc;
                            if (w_cnt_inc == rbrl_pkg::RUN_CNT_BUTTON) begin
                                // second qualifying run closes here
                                n_end_col = i_col - ONE;
                                n_len     = w_base_len;
                                if (w_base_len == '0) begin
                                    // empty run: bottom edge is this very row
                                    n_height = '0;
                                    n_crow   = i_row;
                                    n_ccol   = i_col - ONE;
                                    n_phase  = rbrl_pkg::PH_FOUND;
                                end else begin
                                    n_height = ONE;
                                    n_phase  = rbrl_pkg::PH_COL;
                                end
                            end
                        end
                    end
                end
            end
            rbrl_pkg::PH_COL: begin
                if ((i_col == r_end_col) && (i_row > r_cur_row) && (i_row < i_row_stop)) begin
                    if (i_match.hit) begin
                        if (r_height != ALL_ONES) begin
                            n_height = r_height + ONE;
                        end
                    end else begin
                        n_crow  = i_row - (r_height >> 1);
                        n_ccol  = r_end_col - (r_len >> 1);
                        n_phase = rbrl_pkg::PH_FOUND;
                    end
                end
            end
            rbrl_pkg::PH_FOUND: ;
            default: n_phase = rbrl_pkg::PH_ROW;
        endcase
    end

    // frame result, fields zero when nothing was found
    assign w_found      = (n_phase == rbrl_pkg::PH_FOUND);
    assign o_res_valid  = i_en && i_frame_end;
    assign o_found      = w_found;
    assign o_center_col = w_found ? n_ccol   : '0;
    assign o_center_row = w_found ? n_crow   : '0;
    assign o_btn_width  = w_found ? n_len    : '0;
    assign o_btn_height = w_found ? n_height : '0;

endmodule

// ===== src/rbrl_checker.sv =====
`timescale 1ns / 1ps

module rbrl_checker #(
    parameter int COORD_BITS = rbrl_pkg::COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic                  o_found,
    input logic [COORD_BITS-1:0] o_center_col,
    input logic [COORD_BITS-1:0] o_center_row,
    input logic [COORD_BITS-1:0] o_btn_width,
    input logic [COORD_BITS-1:0] o_btn_height
);

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result item dropped while stalled");

    // no result straight after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result item offered after reset");

    // a frame with no button reports all zero fields
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> (o_center_col == '0) && (o_center_row == '0) &&
                                (o_btn_width == '0) && (o_btn_height == '0))
        else $error("non-zero fields on a frame without a button");

    // an empty second run ends the search at once with no height
    a_empty_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found && (o_btn_width == '0) |-> (o_btn_height == '0))
        else $error("height counted for an empty run");

endmodule

bind raster_button_run_locator rbrl_checker #(.COORD_BITS(COORD_BITS)) u_rbrl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_found      (o_found),
    .o_center_col (o_center_col),
    .o_center_row (o_center_row),
    .o_btn_width  (o_btn_width),
    .o_btn_height (o_btn_height)
);
